[rtl/moving_average_filter_unit_defines.svh]
// Assertion macros shared by the moving average filter RTL.
// No dependencies; included by the top level where it asserts.
`ifndef MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define MAF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving average filter check failed");

// Next-cycle implication, checked on clk, quiet while arst_n is low.
`define MAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving average filter check failed");

`endif

[rtl/maf_pkg.sv]
// Shared types and fixed widths for the moving average filter.
// No dependencies; imported by maf_div and the top level.
package maf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV
	} maf_state_t;

	typedef enum logic {
		CMD_FILTER = 1'b0,
		CMD_CLEAR  = 1'b1
	} maf_cmd_t;

	typedef struct packed {
		logic start;
		logic take;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/moving_average_filter_unit.sv]
// Moving average filter unit: boxcar average over the last window_length samples.
// Depends on maf_pkg, maf_ram, maf_div and moving_average_filter_unit_defines.svh.
//
// Input channel (in_valid/in_stall): command and sample; command clear empties
// the history, index and sum and answers zero. Output channel (out_valid/
// out_stall): average, the running sum divided by the length, toward zero.
// An item is accepted when valid is high and stall is low.
// The serial divider works over SUM_W = 16 + log2(MAX_LENGTH) bits, one
// quotient bit per cycle; items are taken one at a time and the next one
// can be accepted in the cycle in which out_valid rises.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished quotient waits in the divider
// and the input stalls until the output register frees up.
// Reset sets the length to 1 and empties the history; no clearing pass is
// needed since history entries read as zero until the ring has wrapped once.
// cfg_write loads window_length (0 acts as 1, clamped to MAX_LENGTH and to 127); a
// changed length empties the history. Write it only while the unit is idle.
module moving_average_filter_unit #(
	parameter int MAX_LENGTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [maf_pkg::LEN_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic signed [maf_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [maf_pkg::SAMPLE_W-1:0] average
);
	import maf_pkg::*;

	localparam int IDX_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int SUM_W     = SAMPLE_W + IDX_W;
	localparam int CMP_W     = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
	localparam int LEN_LIMIT = (MAX_LENGTH < (1 << LEN_W)) ? MAX_LENGTH
		: (1 << LEN_W) - 1;

	maf_state_t state_q, state_d;

	logic [LEN_W-1:0]          len_q;
	logic [IDX_W-1:0]          head_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      filled_q;

	logic                      cmd_s1;
	logic [IDX_W-1:0]          head_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	logic                      out_valid_q;
	logic signed [SAMPLE_W-1:0] average_q;

	logic                      accept;
	logic                      out_free;
	logic                      ram_we;
	logic [IDX_W-1:0]          head_next;
	logic [CMP_W-1:0]          head_inc;
	logic [SAMPLE_W-1:0]       ram_rdata;
	logic signed [SUM_W-1:0]   old_ext;
	logic signed [SUM_W-1:0]   new_ext;
	logic signed [SUM_W-1:0]   sum_new;
	logic [LEN_W-1:0]          len_clamped;

	div_ctrl_t                 div_ctrl;
	div_stat_t                 div_stat;
	logic signed [SAMPLE_W-1:0] div_quo;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ring advance, wraps at the configured length
	assign head_inc  = CMP_W'(head_q) + CMP_W'(1);
	assign head_next = (head_inc >= CMP_W'(len_q)) ? '0 : head_inc[IDX_W-1:0];

	// entries not yet rewritten since the last clear read as zero
	assign old_ext = filled_q ? {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata} : '0;
	assign new_ext = {{(SUM_W-SAMPLE_W){sample_s1[SAMPLE_W-1]}}, sample_s1};
	assign sum_new = (cmd_s1 == CMD_CLEAR) ? '0 : (sum_q - old_ext + new_ext);

	always_comb begin
		len_clamped = cfg_data;
		if (cfg_data == '0) begin
			len_clamped = LEN_W'(1);
		end else if (cfg_data > LEN_W'(LEN_LIMIT)) begin
			len_clamped = LEN_W'(LEN_LIMIT);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall      = 1'b1;
		ram_we        = 1'b0;
		div_ctrl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_UPD: begin
				ram_we         = (cmd_s1 == CMD_FILTER);
				div_ctrl.start = 1'b1;
			end
			ST_DIV: begin
				div_ctrl.take = div_stat.done && out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= LEN_W'(1);
			head_q      <= '0;
			sum_q       <= '0;
			filled_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && (len_clamped != len_q)) begin
				len_q    <= len_clamped;
				head_q   <= '0;
				sum_q    <= '0;
				filled_q <= 1'b0;
			end else if (state_q == ST_UPD) begin
				sum_q <= sum_new;
				if (cmd_s1 == CMD_CLEAR) begin
					head_q   <= '0;
					filled_q <= 1'b0;
				end else begin
					head_q <= head_s1;
					if (head_s1 == '0) begin
						filled_q <= 1'b1;
					end
				end
			end
			if (div_ctrl.take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			head_s1   <= head_next;
			sample_s1 <= sample;
		end
		if (div_ctrl.take) begin
			average_q <= div_quo;
		end
	end

	maf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_LENGTH)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_s1),
		.wdata (sample_s1),
		.raddr (head_next),
		.rdata (ram_rdata)
	);

	maf_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (sum_new),
		.divisor  (len_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign average   = average_q;

`include "moving_average_filter_unit_defines.svh"

	`MAF_ASSERT_IMPL(a_len_in_range, 1'b1, (len_q != '0) && (len_q <= LEN_W'(LEN_LIMIT)))
	`MAF_ASSERT_IMPL(a_head_below_len, state_q == ST_IDLE, CMP_W'(head_q) < CMP_W'(len_q))
	`MAF_ASSERT_NEXT(a_div_starts, state_q == ST_UPD, div_stat.busy && !div_stat.done)
	`MAF_ASSERT_IMPL(a_take_when_done, div_ctrl.take, div_stat.done && (state_q == ST_DIV))

endmodule

[rtl/maf_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies; holds the sample history of the filter.
module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/maf_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero.
// Depends on maf_pkg for the length width and control/status structs.
module maf_div #(
	parameter int SUM_W = 22
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  maf_pkg::div_ctrl_t            ctrl,
	input  logic signed [SUM_W-1:0]       dividend,
	input  logic [maf_pkg::LEN_W-1:0]     divisor,
	output maf_pkg::div_stat_t            stat,
	output logic signed [maf_pkg::SAMPLE_W-1:0] quotient
);
	import maf_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quo_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] dvs_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SUM_W-1:0] mag;
	logic [LEN_W:0]   shifted;
	logic [LEN_W+1:0] diff;
	logic [SUM_W-1:0] signed_quo;

	assign mag     = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (ctrl.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (ctrl.take) begin
				done_q <= 1'b0;
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			if (!diff[LEN_W+1]) begin
				rem_q <= diff[LEN_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[LEN_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign signed_quo = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign quotient   = signed_quo[SAMPLE_W-1:0];
	assign stat.busy  = busy_q;
	assign stat.done  = done_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for moving_average_filter_unit: drives samples, clear commands
// and length writes, predicts every average and checks each output item in order.
// Depends on maf_pkg and the filter RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import maf_pkg::*;

	localparam int RING_DEPTH   = 64;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 120;
	localparam int RANDOM_ITEMS = 450;
	localparam int SETTLE_TAIL  = 30;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

	// Tracks the ring, the running sum and the length; queues one average per item.
	class average_tracker;
		logic signed [SAMPLE_W-1:0] ring[RING_DEPTH];
		logic signed [SAMPLE_W-1:0] pending_averages[$];
		int unsigned head;
		int unsigned length;
		int          sum;
		int          checked;
		int          mismatches;

		function new();
			length     = 1;
			checked    = 0;
			mismatches = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (ring[i]) ring[i] = '0;
			head = 0;
			sum  = 0;
		endfunction

		function int unsigned clamp_length(logic [LEN_W-1:0] value);
			int unsigned l;
			l = value;
			if (l < 1) l = 1;
			if (l > RING_DEPTH) l = RING_DEPTH;
			return l;
		endfunction

		function void write_length(logic [LEN_W-1:0] value);
			int unsigned l;
			l = clamp_length(value);
			// an equal length keeps the history
			if (l != length) begin
				length = l;
				wipe();
			end
		endfunction

		function void note_input(maf_cmd_t cmd, logic signed [SAMPLE_W-1:0] value);
			logic signed [SAMPLE_W-1:0] avg;
			if (cmd == CMD_CLEAR) begin
				wipe();
				pending_averages.push_back('0);
				return;
			end
			head = head + 1;
			if (head >= length) head = 0;
			sum = sum - ring[head];
			ring[head] = value;
			sum = sum + value;
			// int division truncates toward zero
			avg = SAMPLE_W'(sum / int'(length));
			pending_averages.push_back(avg);
		endfunction

		function void check_average(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (pending_averages.size() == 0) begin
				$display("%0t: unexpected output item, got %0d", $time, got);
				mismatches++;
				return;
			end
			want = pending_averages.pop_front();
			checked++;
			if (got !== want) begin
				$display("%0t: average mismatch, expected %0d, got %0d", $time, want, got);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_averages.size();
		endfunction
	endclass

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [LEN_W-1:0]           cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic                       command   = CMD_FILTER;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] average;

	average_tracker tracker = new();

	int          cycles       = 0;
	int          results_seen = 0;
	int          items_sent   = 0;
	int          clears_sent  = 0;
	int          gap_mode     = 0;
	int          sample_mode  = 0;
	logic [64:0] lengths_used = '0;

	moving_average_filter_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.sample   (sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average  (average)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d averages outstanding", cycles, tracker.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_average(average);
			results_seen++;
		end
	end

	// Output side: random stall spans, plus one long hold-off so the input backs up.
	initial begin
		int  stall_mode;
		int  span;
		int  stall_left;
		bit  held_off;
		stall_left = 0;
		held_off   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall_mode = $urandom_range(0, 3);
			span       = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				if (!held_off && results_seen >= HOLD_AFTER) begin
					held_off = 1'b1;
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				if (stall_left == 0) begin
					case (stall_mode)
						1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
						2: if ($urandom_range(0, 31) == 0) stall_left = $urandom_range(10, 60);
						3: begin
							if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
							else if ($urandom_range(0, 47) == 0) stall_left = $urandom_range(10, 60);
						end
						default: stall_left = 0;
					endcase
				end
				if (stall_left > 0) begin
					stall_left--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	function automatic int pick_gap();
		case (gap_mode)
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			2: return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case (sample_mode)
			1: return S_MAX;
			2: return S_MIN;
			3: begin
				case ($urandom_range(0, 4))
					0: return S_MAX;
					1: return S_MIN;
					2: return 16'sd0;
					3: return 16'sd1;
					default: return -16'sd1;
				endcase
			end
			4: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input maf_cmd_t cmd, input logic signed [SAMPLE_W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command  <= cmd;
		sample   <= value;
		do @(posedge clk); while (in_stall);
		tracker.note_input(cmd, value);
		items_sent++;
		if (cmd == CMD_CLEAR) clears_sent++;
	endtask

	// Length writes only go in once every expected average has come out.
	task automatic set_length(input logic [LEN_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		tracker.write_length(value);
		lengths_used[tracker.length] = 1'b1;
	endtask

	task automatic run_phase(input int count, input bit with_clears);
		maf_cmd_t cmd;
		repeat (count) begin
			cmd = (with_clears && $urandom_range(0, 23) == 0) ? CMD_CLEAR : CMD_FILTER;
			send_item(cmd, pick_sample());
		end
	endtask

	initial begin
		int          random_items;
		int          n;
		int unsigned eff;
		logic [LEN_W-1:0] len_value;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		lengths_used[1] = 1'b1;

		// directed: extremes at the reset length, then truncation at length 3
		gap_mode = 0;
		send_item(CMD_FILTER, S_MAX);
		send_item(CMD_FILTER, S_MIN);
		send_item(CMD_FILTER, 16'sd0);
		send_item(CMD_FILTER, -16'sd1);
		send_item(CMD_FILTER, 16'sd1);
		send_item(CMD_FILTER, 16'sh5555);
		send_item(CMD_CLEAR, 16'shaaaa);
		set_length(7'd3);
		repeat (3) send_item(CMD_FILTER, S_MAX);
		repeat (3) send_item(CMD_FILTER, S_MIN);
		send_item(CMD_FILTER, -16'sd1);
		send_item(CMD_CLEAR, 16'sh0000);
		send_item(CMD_FILTER, 16'sd1);
		send_item(CMD_FILTER, -16'sd2);
		send_item(CMD_FILTER, S_MIN);
		// zero acts as one and differs from three, so history clears
		set_length(7'd0);
		send_item(CMD_FILTER, -16'sd7);

		// full window of maxima, then an equal-length rewrite and minima
		set_length(7'd127);
		gap_mode    = 1;
		sample_mode = 1;
		run_phase(80, 1'b0);
		set_length(7'd64);
		gap_mode    = 2;
		sample_mode = 2;
		run_phase(80, 1'b0);
		random_items = 160;

		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: len_value = 7'd0;
				1: len_value = 7'd1;
				2: len_value = 7'd2;
				3: len_value = 7'd63;
				4: len_value = 7'd64;
				5: len_value = 7'd127;
				default: len_value = LEN_W'($urandom_range(0, 127));
			endcase
			set_length(len_value);
			eff         = tracker.length;
			n           = $urandom_range(8, 2 * eff + 16);
			if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
			gap_mode    = $urandom_range(0, 2);
			sample_mode = $urandom_range(0, 4);
			run_phase(n, 1'b1);
			random_items += n;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_TAIL) @(posedge clk);

		$display("Sent %0d items (%0d clears), checked %0d averages, %0d mismatches",
			items_sent, clears_sent, tracker.checked, tracker.mismatches);
		$display("Window lengths exercised: %0d distinct, long output hold-off included",
			$countones(lengths_used));
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
